[src/skts_pkg.sv]
// Shared constants and codes for the sorted key table search block.
package skts_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_WIDTH_DEF   = 16;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_SORT   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

endpackage

[src/skts_if.sv]
// Valid/ready channel interfaces for command words and result words.
interface skts_req_if import skts_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface skts_rsp_if import skts_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [5:0]  slot_index;
  logic [15:0] image_number;

  modport source (output valid, output status, output found, output slot_index,
                  output image_number, input ready);
  modport sink   (input valid, input status, input found, input slot_index,
                  input image_number, output ready);
endinterface

[src/sorted_key_table_search_core.sv]
// Sorted key table: append, shell sort and binary search lookup over one RAM.
//
// Usage: command words enter on req (cmd, key) with a valid/ready handshake;
// one result word per command leaves on rsp (status, found, slot_index,
// image_number). req.ready is high only while the sequencer is idle.
// A lookup makes at most log2(TABLE_DEPTH)+1 binary search probes; a sort
// runs shell sort passes whose gap starts at a quarter of the entry count
// (at least 1) and halves down to 1. A new command is taken only after the
// previous command's result has moved to the output register. All table
// work goes through the single key RAM with one registered read and one
// write each cycle, so every probe and every shift costs a RAM read
// turnaround.
// One result word is held in an output register: the next command is taken
// while it waits, and that command's result waits in the sequencer until
// rsp.ready frees the register. A stalled receiver never loses a word.
// Reset clears the entry count and the control state; RAM contents are not
// cleared, only entries below the count are ever read.
module sorted_key_table_search_core
  import skts_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  skts_req_if.sink   req,
  skts_rsp_if.source rsp
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD_I, S_HOLD, S_CHK, S_CMP, S_NEXT_I,
    S_SRCH, S_PROBE, S_DONE
  } state_t;

  state_t               state;
  logic [KEY_WIDTH-1:0] key_store [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rdata;
  logic [KEY_WIDTH-1:0] key_reg;
  logic [KEY_WIDTH-1:0] held;
  logic [1:0]           cmd_reg;
  logic [CW-1:0]        entry_count;
  logic [CW-1:0]        gap;
  logic [CW-1:0]        i;
  logic [CW-1:0]        j;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        hx;
  logic [CW-1:0]        mid;
  logic [1:0]           pend_status;
  logic                 pend_found;
  logic [5:0]           pend_slot;
  logic [15:0]          pend_image;
  logic                 ovalid;
  logic [1:0]           ostatus;
  logic                 ofound;
  logic [5:0]           oslot;
  logic [15:0]          oimage;

  logic                 we;
  logic [IW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [IW-1:0]        raddr;
  logic [31:0]          key32;
  logic [31:0]          probe32;
  logic [31:0]          mid32;
  logic [CW-1:0]        mid_calc;
  logic [CW-1:0]        jmg;
  logic [CW-1:0]        gap_init;

  assign key32    = 32'(req.key);
  assign probe32  = 32'(rdata);
  assign mid32    = 32'(mid);
  assign mid_calc = CW'(({1'b0, lo} + {1'b0, hx} - (CW+1)'(1)) >> 1);
  assign jmg      = j - gap;
  assign gap_init = ((entry_count >> 2) == '0) ? CW'(1) : (entry_count >> 2);

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = ovalid;
  assign rsp.status       = ostatus;
  assign rsp.found        = ofound;
  assign rsp.slot_index   = oslot;
  assign rsp.image_number = oimage;

  always_comb begin
    we    = 1'b0;
    waddr = entry_count[IW-1:0];
    wdata = key_reg;
    raddr = i[IW-1:0];
    unique case (state)
      S_DISPATCH: begin
        we = (cmd_reg == CMD_APPEND) && (entry_count < CW'(TABLE_DEPTH));
      end
      S_CHK: begin
        raddr = jmg[IW-1:0];
        if (j < gap) begin
          we    = 1'b1;
          waddr = j[IW-1:0];
          wdata = held;
        end
      end
      S_CMP: begin
        we    = 1'b1;
        waddr = j[IW-1:0];
        wdata = (rdata > held) ? rdata : held;
      end
      S_SRCH: raddr = mid_calc[IW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_store[waddr] <= wdata;
    end
    rdata <= key_store[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      ovalid      <= 1'b0;
    end else begin
      if (ovalid && rsp.ready && (state != S_DONE)) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_reg <= req.cmd;
            key_reg <= key32[KEY_WIDTH-1:0];
            state   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          pend_status <= STAT_OK;
          pend_found  <= 1'b0;
          pend_slot   <= '0;
          pend_image  <= '0;
          state       <= S_DONE;
          unique case (cmd_reg)
            CMD_APPEND: begin
              if (entry_count < CW'(TABLE_DEPTH)) begin
                entry_count <= entry_count + CW'(1);
              end else begin
                pend_status <= STAT_FULL;
              end
            end
            CMD_SORT: begin
              gap <= gap_init;
              i   <= '0;
              if (entry_count > CW'(1)) begin
                state <= S_RD_I;
              end
            end
            CMD_LOOKUP: begin
              pend_status <= STAT_MISS;
              lo          <= '0;
              hx          <= entry_count;
              state       <= S_SRCH;
            end
            default: ;
          endcase
        end
        S_RD_I: state <= S_HOLD;
        S_HOLD: begin
          held  <= rdata;
          j     <= i;
          state <= S_CHK;
        end
        S_CHK: begin
          state <= (j < gap) ? S_NEXT_I : S_CMP;
        end
        S_CMP: begin
          if (rdata > held) begin
            j     <= jmg;
            state <= S_CHK;
          end else begin
            state <= S_NEXT_I;
          end
        end
        S_NEXT_I: begin
          if (i + CW'(1) < entry_count) begin
            i     <= i + CW'(1);
            state <= S_RD_I;
          end else begin
            gap <= gap >> 1;
            i   <= '0;
            state <= ((gap >> 1) == '0) ? S_DONE : S_RD_I;
          end
        end
        S_SRCH: begin
          if (lo < hx) begin
            mid   <= mid_calc;
            state <= S_PROBE;
          end else begin
            state <= S_DONE;
          end
        end
        S_PROBE: begin
          if (key_reg > rdata) begin
            lo    <= mid + CW'(1);
            state <= S_SRCH;
          end else if (key_reg < rdata) begin
            hx    <= mid;
            state <= S_SRCH;
          end else begin
            pend_status <= STAT_OK;
            pend_found  <= 1'b1;
            pend_slot   <= mid32[5:0];
            pend_image  <= probe32[15:0] & ~16'd3;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ovalid || rsp.ready) begin
            ovalid  <= 1'b1;
            ostatus <= pend_status;
            ofound  <= pend_found;
            oslot   <= pend_slot;
            oimage  <= pend_image;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for sorted_key_table_search_core: random and directed command words.
module tb_top;
  import skts_pkg::*;

  localparam int          DEPTH        = TABLE_DEPTH_DEF;
  localparam int          RANDOM_WORDS = 1500;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          CYCLE_LIMIT  = 3000000;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [15:0] CORNER_KEYS [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] key;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [5:0]  slot;
    logic [15:0] image;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst;

  skts_req_if req_ch ();
  skts_rsp_if rsp_ch ();

  sorted_key_table_search_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  cmd_word_t    cmd_words_todo [$];
  table_reply_t replies_due [$];
  logic [15:0]  planned_keys [$];

  logic [15:0]  tbl [DEPTH];
  int           tbl_count = 0;
  int           n_append = 0, n_dropped = 0, n_sort = 0, n_lookup = 0, n_hit = 0;
  int           n_unused = 0;
  int           mismatches = 0;
  int           words_sent;
  int           replies_seen;
  int           send_pause;
  int           recv_pause;
  int           hold_left;
  int           cycles = 0;

  // Next table state and the reply word that one command produces.
  function automatic table_reply_t table_step(logic [1:0] op, logic [15:0] k);
    table_reply_t r;
    int           lo, hi, mid, gap, i, j;
    logic [15:0]  held;
    bit           hit;
    r = '{status: STAT_OK, found: 1'b0, slot: 6'd0, image: 16'd0};
    case (op)
      CMD_APPEND: begin
        if (tbl_count < DEPTH) begin
          tbl[tbl_count] = k;
          tbl_count++;
          n_append++;
        end else begin
          r.status = STAT_FULL;
          n_dropped++;
        end
      end
      CMD_SORT: begin
        n_sort++;
        gap = tbl_count >> 2;
        if (gap < 1) gap = 1;
        while (gap > 0) begin
          for (i = 0; i < tbl_count; i++) begin
            held = tbl[i];
            j = i;
            while (j >= gap && tbl[j - gap] > held) begin
              tbl[j] = tbl[j - gap];
              j -= gap;
            end
            tbl[j] = held;
          end
          gap = gap >> 1;
        end
      end
      CMD_LOOKUP: begin
        n_lookup++;
        r.status = STAT_MISS;
        lo = 0;
        hi = tbl_count - 1;
        hit = 1'b0;
        while (!hit && lo <= hi) begin
          mid = (lo + hi) / 2;
          if (k > tbl[mid]) begin
            lo = mid + 1;
          end else if (k < tbl[mid]) begin
            hi = mid - 1;
          end else begin
            hit = 1'b1;
            n_hit++;
            r.status = STAT_OK;
            r.found = 1'b1;
            r.slot = mid[5:0];
            r.image = {tbl[mid][15:2], 2'b00};
          end
        end
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  // Mostly short pauses, a few long ones, and periodic stretches with none.
  function automatic int draw_pause(int seq);
    int r;
    r = $urandom_range(0, 99);
    if ((seq % 256) < 48) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic queue_cmd(logic [1:0] op, logic [15:0] k);
    cmd_words_todo.push_back('{op: op, key: k});
    if (op == CMD_APPEND && planned_keys.size() < DEPTH) planned_keys.push_back(k);
  endtask

  // Command driver
  always @(posedge clk) begin : cmd_driver
    cmd_word_t w;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_APPEND;
      req_ch.key <= 16'd0;
      send_pause <= 0;
      words_sent <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        replies_due.push_back(table_step(req_ch.cmd, req_ch.key));
        words_sent <= words_sent + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_pause > 0) begin
          send_pause <= send_pause - 1;
          req_ch.valid <= 1'b0;
        end else if (cmd_words_todo.size() > 0) begin
          w = cmd_words_todo.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.cmd <= w.op;
          req_ch.key <= w.key;
          send_pause <= draw_pause(words_sent);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (rsp_ch.valid && rsp_ch.ready &&
                 (replies_seen == 300 || replies_seen == 1100)) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Result monitor
  always @(posedge clk) begin : reply_monitor
    table_reply_t want;
    int           g;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_pause <= 0;
      replies_seen <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        replies_seen <= replies_seen + 1;
        if (replies_due.size() == 0) begin
          $error("result word with no command outstanding");
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            mismatches++;
          end
          if (rsp_ch.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
            mismatches++;
          end
          if (rsp_ch.slot_index !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, rsp_ch.slot_index);
            mismatches++;
          end
          if (rsp_ch.image_number !== want.image) begin
            $error("image_number: expected %0h, got %0h", want.image, rsp_ch.image_number);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
      end else if (recv_pause != 0) begin
        recv_pause <= recv_pause - 1;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
        g = draw_pause(replies_seen + 128);
        recv_pause <= (g > 0) ? g - 1 : 0;
        rsp_ch.ready <= (g == 0);
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 9) != 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** sorted_key_table_search_core: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int          r;
    int          idx;
    logic [1:0]  op;
    logic [15:0] k;
    rst = 1'b1;

    // empty table, unused code, single entry, unsorted probe, small-table sort, duplicates
    queue_cmd(CMD_LOOKUP, 16'h0000);
    queue_cmd(CMD_SORT,   16'h0000);
    queue_cmd(CMD_UNUSED, 16'hFFFF);
    queue_cmd(CMD_APPEND, 16'hFFFF);
    queue_cmd(CMD_SORT,   16'hFFFF);
    queue_cmd(CMD_LOOKUP, 16'hFFFF);
    queue_cmd(CMD_APPEND, 16'h0000);
    queue_cmd(CMD_LOOKUP, 16'h0000);
    queue_cmd(CMD_APPEND, 16'h1235);
    queue_cmd(CMD_SORT,   16'h0000);
    queue_cmd(CMD_LOOKUP, 16'h1235);
    queue_cmd(CMD_APPEND, 16'h1235);
    queue_cmd(CMD_APPEND, 16'h8000);
    queue_cmd(CMD_SORT,   16'h5A5A);
    queue_cmd(CMD_LOOKUP, 16'h1235);
    queue_cmd(CMD_LOOKUP, 16'h1234);
    queue_cmd(CMD_LOOKUP, 16'hFFFF);
    queue_cmd(CMD_LOOKUP, 16'h0000);
    queue_cmd(CMD_UNUSED, 16'h0000);

    repeat (RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (planned_keys.size() < DEPTH)
        op = (r < 40) ? CMD_APPEND : (r < 85) ? CMD_LOOKUP : (r < 95) ? CMD_SORT : CMD_UNUSED;
      else
        op = (r < 10) ? CMD_APPEND : (r < 90) ? CMD_LOOKUP : (r < 96) ? CMD_SORT : CMD_UNUSED;
      k = 16'($urandom_range(0, 16'hFFFF));
      r = $urandom_range(0, 99);
      idx = (planned_keys.size() > 0) ? $urandom_range(0, planned_keys.size() - 1) : 0;
      case (op)
        CMD_APPEND: begin
          if (r < 30) k = 16'($urandom_range(0, 15));
          else if (r < 45) k = CORNER_KEYS[$urandom_range(0, 3)];
          else if (r < 60 && planned_keys.size() > 0) k = planned_keys[idx];
        end
        CMD_LOOKUP: begin
          if (planned_keys.size() > 0 && r < 65) k = planned_keys[idx];
          else if (planned_keys.size() > 0 && r < 80)
            k = planned_keys[idx] + ((r < 72) ? 16'd1 : 16'hFFFF);
        end
        default: ;
      endcase
      queue_cmd(op, k);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (cmd_words_todo.size() != 0 || req_ch.valid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands in %0d cycles: %0d appends stored, %0d dropped on full table,",
             words_sent, cycles, n_append, n_dropped);
    $display("%0d sorts, %0d lookups (%0d hits), %0d unused codes, %0d receiver holds of %0d cycles.",
             n_sort, n_lookup, n_hit, n_unused, 2, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("** sorted_key_table_search_core: PASSED **");
    end else begin
      $display("** sorted_key_table_search_core: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
src/skts_pkg.sv
src/skts_if.sv
src/sorted_key_table_search_core.sv
tb/tb_top.sv
